// ===== rtl/core/wssd_pkg.sv =====
package wssd_pkg;

	localparam int WINDOW_MAX  = 256;
	localparam int SAMPLE_BITS = 16;

	localparam int LEN_W    = 9;
	localparam int LIMIT_W  = 16;
	localparam int COUNT_W  = 32;
	localparam int SPREAD_W = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// cell index split for the two-level readout
	localparam int IDX_W    = $clog2(WINDOW_MAX);
	localparam int LO_W     = IDX_W / 2;
	localparam int HI_W     = IDX_W - LO_W;
	localparam int NUM_GRP  = 1 << HI_W;
	localparam int GRP_SIZE = 1 << LO_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_LEN   = 1'b0,
		REG_SPREAD_LIMIT = 1'b1
	} reg_idx_t;

	// running extremes of the newest samples
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] hi;
		logic signed [SAMPLE_BITS-1:0] lo;
	} ext_t;

	// per-window bookkeeping that travels down the readout pipeline
	typedef struct packed {
		logic [COUNT_W-1:0] start;
		logic [IDX_W-1:0]   idx;
	} tag_t;

endpackage

// ===== rtl/core/wssd_ifs.sv =====
interface wssd_sample_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [wssd_pkg::SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface wssd_result_if;
	logic                            valid;
	logic                            ready;
	logic [wssd_pkg::COUNT_W-1:0]    start_position;
	logic [wssd_pkg::SPREAD_W-1:0]   spread;

	modport source (output valid, output start_position, output spread, input ready);
	modport sink (input valid, input start_position, input spread, output ready);
endinterface

interface wssd_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [wssd_pkg::CFG_IDX_W-1:0]    index;
	logic [wssd_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/wssd_cell.sv =====
// Cell j holds max/min of the newest j+1 samples. On each sample transfer it
// merges the new sample into its left neighbor's extremes.
module wssd_cell (
	input  logic                                   clk,
	input  logic                                   shift,
	input  logic signed [wssd_pkg::SAMPLE_BITS-1:0] sample,
	input  wssd_pkg::ext_t                         prev,
	output wssd_pkg::ext_t                         ext
);

	wssd_pkg::ext_t ext_q;
	wssd_pkg::ext_t ext_d;

	always_comb begin
		ext_d.hi = (sample > prev.hi) ? sample : prev.hi;
		ext_d.lo = (sample < prev.lo) ? sample : prev.lo;
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			ext_q <= ext_d;
		end
	end

	assign ext = ext_q;

endmodule

// ===== rtl/core/wssd_select.sv =====
// Reads the cell for the current window length in two registered steps, then
// checks the spread against the limit and holds the result for the receiver.
module wssd_select (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  wssd_pkg::ext_t                    cells [wssd_pkg::WINDOW_MAX],
	input  logic                              valid_s1,
	input  wssd_pkg::tag_t                    tag_s1,
	input  logic [wssd_pkg::LIMIT_W-1:0]      limit,
	output logic                              res_valid,
	output logic [wssd_pkg::COUNT_W-1:0]      res_start,
	output logic [wssd_pkg::SPREAD_W-1:0]     res_spread
);

	wssd_pkg::ext_t grp_s2 [wssd_pkg::NUM_GRP];
	wssd_pkg::tag_t tag_s2;
	logic           valid_s2;

	wssd_pkg::ext_t ext_s3;
	logic [wssd_pkg::COUNT_W-1:0] start_s3;
	logic           valid_s3;

	logic                          valid_s4;
	logic [wssd_pkg::COUNT_W-1:0]  start_s4;
	logic [wssd_pkg::SPREAD_W-1:0] spread_s4;

	logic signed [wssd_pkg::SAMPLE_BITS:0] diff;
	logic                                  quiet;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3 && quiet;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int g = 0; g < wssd_pkg::NUM_GRP; g++) begin
				grp_s2[g] <= cells[{wssd_pkg::HI_W'(g), tag_s1.idx[wssd_pkg::LO_W-1:0]}];
			end
			tag_s2   <= tag_s1;
			ext_s3   <= grp_s2[tag_s2.idx[wssd_pkg::IDX_W-1:wssd_pkg::LO_W]];
			start_s3 <= tag_s2.start;
			start_s4 <= start_s3;
			spread_s4 <= wssd_pkg::SPREAD_W'(diff);
		end
	end

	// diff is never negative: hi >= lo in every cell
	always_comb begin
		diff  = {ext_s3.hi[wssd_pkg::SAMPLE_BITS-1], ext_s3.hi}
			- {ext_s3.lo[wssd_pkg::SAMPLE_BITS-1], ext_s3.lo};
		quiet = {1'b0, diff} <= {{(wssd_pkg::SAMPLE_BITS + 2 - wssd_pkg::LIMIT_W){1'b0}}, limit};
	end

	assign res_valid  = valid_s4;
	assign res_start  = start_s4;
	assign res_spread = spread_s4;

endmodule

// ===== rtl/core/window_spread_silence_detector_unit.sv =====
// Quiet-window detector.
// samples (sink): one signed audio sample per transfer.
// results (source): start_position (1-based index of the window's first
//   sample) and spread (max - min), only for windows whose spread is at most
//   spread_limit. Windows that are not yet full or too loud give nothing.
// cfg (sink, always ready): index 0 window_len (0 acts as 1, above 256 acts
//   as 256), index 1 spread_limit. Write only while the block is idle.
// Throughput: one sample per cycle while not stalled. A row of 256 cells,
//   cell j holding the extremes of the newest j+1 samples, is updated by
//   every sample transfer.
// Pipeline: the cells update on the sample transfer edge; the readout then
//   registers a cell group, then the cell, then the compared result.
// Stall: the pipeline and the output register stop together while a result
//   waits; samples are taken whenever the output register is empty or is
//   being emptied in that cycle.
// Reset: window_len 1, spread_limit 0, sample count 0, no result pending.
//   The sample count saturates at 2^32-1.
module window_spread_silence_detector_unit (
	input  logic           clk,
	input  logic           arst_n,
	wssd_sample_if.sink    samples,
	wssd_result_if.source  results,
	wssd_cfg_if.sink       cfg
);

	logic [wssd_pkg::LEN_W-1:0]   win_len_q;
	logic [wssd_pkg::LIMIT_W-1:0] limit_q;
	logic [wssd_pkg::COUNT_W-1:0] count_q;
	logic [wssd_pkg::COUNT_W-1:0] count_nxt;
	logic [wssd_pkg::LEN_W-1:0]   eff_len;

	logic en;
	logic acc;
	logic full;

	logic           valid_s1;
	wssd_pkg::tag_t tag_s1;

	wssd_pkg::ext_t cells [wssd_pkg::WINDOW_MAX];
	wssd_pkg::ext_t seed;

	logic                          res_valid;
	logic [wssd_pkg::COUNT_W-1:0]  res_start;
	logic [wssd_pkg::SPREAD_W-1:0] res_spread;

	assign en  = !res_valid || results.ready;
	assign acc = samples.valid && en;
	assign samples.ready = en;
	assign cfg.ready = 1'b1;

	always_comb begin
		if (win_len_q == '0) begin
			eff_len = wssd_pkg::LEN_W'(1);
		end else if (win_len_q > wssd_pkg::LEN_W'(wssd_pkg::WINDOW_MAX)) begin
			eff_len = wssd_pkg::LEN_W'(wssd_pkg::WINDOW_MAX);
		end else begin
			eff_len = win_len_q;
		end
		count_nxt = (count_q == '1) ? count_q : count_q + 1'b1;
		full      = count_nxt >= wssd_pkg::COUNT_W'(eff_len);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_q <= wssd_pkg::LEN_W'(1);
			limit_q   <= '0;
		end else if (cfg.valid) begin
			unique case (wssd_pkg::reg_idx_t'(cfg.index))
				wssd_pkg::REG_WINDOW_LEN:   win_len_q <= cfg.data[wssd_pkg::LEN_W-1:0];
				wssd_pkg::REG_SPREAD_LIMIT: limit_q   <= cfg.data[wssd_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (acc) begin
				count_q <= count_nxt;
			end
			if (en) begin
				valid_s1 <= acc && full;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			tag_s1.start <= count_nxt - wssd_pkg::COUNT_W'(eff_len) + 1'b1;
			tag_s1.idx   <= wssd_pkg::IDX_W'(eff_len - 1'b1);
		end
	end

	// first cell merges the sample with itself
	assign seed.hi = samples.sample;
	assign seed.lo = samples.sample;

	for (genvar j = 0; j < wssd_pkg::WINDOW_MAX; j++) begin : g_cell
		wssd_cell u_cell (
			.clk    (clk),
			.shift  (acc),
			.sample (samples.sample),
			.prev   ((j == 0) ? seed : cells[(j == 0) ? 0 : j - 1]),
			.ext    (cells[j])
		);
	end

	wssd_select u_select (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.cells      (cells),
		.valid_s1   (valid_s1),
		.tag_s1     (tag_s1),
		.limit      (limit_q),
		.res_valid  (res_valid),
		.res_start  (res_start),
		.res_spread (res_spread)
	);

	assign results.valid          = res_valid;
	assign results.start_position = res_start;
	assign results.spread         = res_spread;

	a_count_moves: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> count_q != '0)
		else $error("sample count zero after a sample transfer");

	a_start_one_based: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> results.start_position != '0)
		else $error("result start position is zero");

	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(valid_s1) && $stable(count_q))
		else $error("pipeline moved while the output was stalled");

endmodule

// ===== tb/wssd_quiet_monitor.sv =====
`timescale 1ns / 1ps

module wssd_quiet_monitor (
	input  logic    clk,
	input  logic    arst_n,
	wssd_sample_if  samples,
	wssd_result_if  results,
	wssd_cfg_if     cfg,
	output int      fail_count,
	output int      outstanding
);

	typedef struct packed {
		logic [wssd_pkg::COUNT_W-1:0]  start;
		logic [wssd_pkg::SPREAD_W-1:0] spread;
	} quiet_win_t;

	logic signed [wssd_pkg::SAMPLE_BITS-1:0] history [wssd_pkg::WINDOW_MAX];
	logic [wssd_pkg::IDX_W-1:0]              wr_ptr;
	logic [wssd_pkg::COUNT_W-1:0]            seen;
	logic [wssd_pkg::LEN_W-1:0]              len_reg;
	logic [wssd_pkg::LIMIT_W-1:0]            limit_reg;
	quiet_win_t                              quiet_q [$];

	// models one sample transfer and queues the quiet window it closes, if any
	task automatic absorb_sample(input logic signed [wssd_pkg::SAMPLE_BITS-1:0] s);
		int unsigned                             eff;
		logic [wssd_pkg::IDX_W-1:0]              p;
		logic signed [wssd_pkg::SAMPLE_BITS-1:0] top;
		logic signed [wssd_pkg::SAMPLE_BITS-1:0] bottom;
		logic [wssd_pkg::SAMPLE_BITS:0]          diff;
		quiet_win_t                              win;
		history[wr_ptr] = s;
		wr_ptr = wr_ptr + 1'b1;
		if (seen != '1)
			seen = seen + 1'b1;
		eff = (len_reg == 0) ? 1 :
			((len_reg > wssd_pkg::WINDOW_MAX) ? wssd_pkg::WINDOW_MAX : len_reg);
		if (seen < eff)
			return;
		p = wr_ptr - 1'b1;
		top = history[p];
		bottom = top;
		for (int k = 1; k < eff; k++) begin
			p = p - 1'b1;
			if (history[p] > top)
				top = history[p];
			if (history[p] < bottom)
				bottom = history[p];
		end
		diff = {top[wssd_pkg::SAMPLE_BITS-1], top}
			- {bottom[wssd_pkg::SAMPLE_BITS-1], bottom};
		if (diff > {1'b0, limit_reg})
			return;
		win.start = seen - wssd_pkg::COUNT_W'(eff) + 1'b1;
		win.spread = diff[wssd_pkg::SPREAD_W-1:0];
		quiet_q = {quiet_q, win};
	endtask

	task automatic check_result();
		quiet_win_t want;
		if (quiet_q.size() == 0) begin
			$display("%0t: unexpected result: expected none, got start_position %0d spread %0d",
				$time, results.start_position, results.spread);
			fail_count++;
			return;
		end
		want = quiet_q.pop_front();
		if (results.start_position !== want.start) begin
			$display("%0t: start_position mismatch: expected %0d, got %0d",
				$time, want.start, results.start_position);
			fail_count++;
		end
		if (results.spread !== want.spread) begin
			$display("%0t: spread mismatch: expected %0d, got %0d",
				$time, want.spread, results.spread);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < wssd_pkg::WINDOW_MAX; i++)
				history[i] = '0;
			wr_ptr = '0;
			seen = '0;
			len_reg = wssd_pkg::LEN_W'(1);
			limit_reg = '0;
			quiet_q.delete();
			outstanding = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (wssd_pkg::reg_idx_t'(cfg.index))
					wssd_pkg::REG_WINDOW_LEN:   len_reg = cfg.data[wssd_pkg::LEN_W-1:0];
					wssd_pkg::REG_SPREAD_LIMIT: limit_reg = cfg.data[wssd_pkg::LIMIT_W-1:0];
					default: ;
				endcase
			end
			// a result leaving now always belongs to an earlier sample
			if (results.valid && results.ready)
				check_result();
			if (samples.valid && samples.ready)
				absorb_sample(samples.sample);
			outstanding = quiet_q.size();
		end
	end

endmodule

// ===== tb/window_spread_silence_detector_unit_tb.sv =====
`timescale 1ns / 1ps

module window_spread_silence_detector_unit_tb;

	logic clk;
	logic arst_n;
	bit   calm;
	int   sent;
	int   fail_count;
	int   outstanding;

	wssd_sample_if sample_ch ();
	wssd_result_if result_ch ();
	wssd_cfg_if    cfg_ch ();

	window_spread_silence_detector_unit uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (sample_ch),
		.results (result_ch),
		.cfg     (cfg_ch)
	);

	wssd_quiet_monitor monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.samples     (sample_ch),
		.results     (result_ch),
		.cfg         (cfg_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// result backpressure
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			result_ch.ready <= calm || ($urandom_range(0, 99) >= 27);
		end
	end

	task automatic write_reg(input wssd_pkg::reg_idx_t idx,
			input logic [wssd_pkg::CFG_DATA_W-1:0] d);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= d;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic push_sample(input logic signed [wssd_pkg::SAMPLE_BITS-1:0] s);
		while (!calm && $urandom_range(0, 99) < 27) begin
			sample_ch.valid <= 1'b0;
			@(negedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.sample <= s;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	// drain: samples that close no window can still sit in the pipeline
	task automatic settle();
		sample_ch.valid <= 1'b0;
		wait (outstanding == 0);
		repeat (8) @(negedge clk);
	endtask

	initial begin
		int                                      phase;
		int                                      n;
		int                                      phase_items;
		int                                      run_len;
		int                                      amp;
		int                                      v;
		int unsigned                             eff;
		int unsigned                             limit;
		logic [wssd_pkg::LEN_W-1:0]              len_raw;
		logic signed [wssd_pkg::SAMPLE_BITS-1:0] base;

		arst_n = 1'b0;
		calm = 1'b0;
		sent = 0;
		sample_ch.valid = 1'b0;
		sample_ch.sample = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = wssd_pkg::REG_WINDOW_LEN;
		cfg_ch.data = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: window of one, every sample is quiet
		push_sample(16'sh7FFF);
		push_sample(-16'sh8000);
		settle();

		// upper data bits are outside the register; first windows are not full yet
		write_reg(wssd_pkg::REG_WINDOW_LEN, 16'hFE04);
		write_reg(wssd_pkg::REG_SPREAD_LIMIT, 16'hFFFF);
		push_sample(16'sh0001);
		push_sample(-16'sh0001);
		push_sample(-16'sh8000);
		push_sample(16'sh7FFF);
		push_sample(16'sh5555);
		push_sample(-16'sh5556);
		settle();

		// zero length acts as one
		write_reg(wssd_pkg::REG_WINDOW_LEN, 16'h0200);
		write_reg(wssd_pkg::REG_SPREAD_LIMIT, 16'h0000);
		push_sample(-16'sh8000);
		push_sample(16'sh0001);
		settle();

		// full-scale spread, then one above and at the limit
		write_reg(wssd_pkg::REG_WINDOW_LEN, 16'h0002);
		write_reg(wssd_pkg::REG_SPREAD_LIMIT, 16'hFFFF);
		push_sample(16'sh7FFF);
		push_sample(-16'sh8000);
		settle();
		write_reg(wssd_pkg::REG_SPREAD_LIMIT, 16'hFFFE);
		push_sample(16'sh7FFF);
		push_sample(-16'sh7FFF);
		settle();

		// length above the ring size clamps to it
		write_reg(wssd_pkg::REG_WINDOW_LEN, 16'h01FF);
		write_reg(wssd_pkg::REG_SPREAD_LIMIT, 16'h0064);
		push_sample(16'sh0007);
		push_sample(16'sh0007);
		push_sample(16'sh0007);
		settle();

		phase = 0;
		while (sent < 1050) begin
			if (phase == 0) begin
				len_raw = 9'd256;
				limit = 0;
			end else if (phase == 1) begin
				len_raw = 9'h1FF;
				limit = 65535;
			end else begin
				case ($urandom_range(0, 9))
					0: len_raw = '0;
					1: len_raw = 9'd256;
					2: len_raw = wssd_pkg::LEN_W'($urandom_range(257, 511));
					default: len_raw = wssd_pkg::LEN_W'($urandom_range(1, 16));
				endcase
				case ($urandom_range(0, 7))
					0: limit = 0;
					1: limit = 65535;
					2, 3, 4, 5: limit = $urandom_range(0, 255);
					default: limit = $urandom_range(0, 65535);
				endcase
			end
			eff = (len_raw == 0) ? 1 :
				((len_raw > wssd_pkg::WINDOW_MAX) ? wssd_pkg::WINDOW_MAX : len_raw);
			write_reg(wssd_pkg::REG_WINDOW_LEN, {7'($urandom_range(0, 127)), len_raw});
			write_reg(wssd_pkg::REG_SPREAD_LIMIT, wssd_pkg::LIMIT_W'(limit));
			phase_items = (eff > 64) ? 320 : 70 + $urandom_range(0, 30);
			if (phase_items > 1050 - sent)
				phase_items = 1050 - sent;
			calm = (phase == 3);
			n = 0;
			while (n < phase_items) begin
				if (phase == 2 && n == phase_items / 2) begin
					settle();
				end
				if ($urandom_range(0, 9) < 7) begin
					// quiet stretch above a random level; some stretches exceed the limit
					base = wssd_pkg::SAMPLE_BITS'($urandom);
					if ($urandom_range(0, 3) != 0)
						amp = $urandom_range(0, limit);
					else
						amp = limit + $urandom_range(1, 40);
					if (amp > 65535)
						amp = 65535;
					run_len = eff + $urandom_range(0, eff + 8);
					if (run_len > phase_items - n)
						run_len = phase_items - n;
					repeat (run_len) begin
						v = int'(base) + int'($urandom_range(0, amp));
						if (v > 32767)
							v = 32767;
						push_sample(v[wssd_pkg::SAMPLE_BITS-1:0]);
						n++;
					end
				end else begin
					repeat ($urandom_range(1, 4)) begin
						push_sample(wssd_pkg::SAMPLE_BITS'($urandom));
						n++;
					end
				end
			end
			calm = 1'b0;
			settle();
			phase++;
		end

		if (fail_count == 0 && outstanding == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/wssd_pkg.sv
rtl/core/wssd_ifs.sv
rtl/core/wssd_cell.sv
rtl/core/wssd_select.sv
rtl/core/window_spread_silence_detector_unit.sv
tb/wssd_quiet_monitor.sv
tb/window_spread_silence_detector_unit_tb.sv
